### src/ersm_pkg.sv
// ----------------------------------------------------------------------------
// ersm_pkg - EXP-rule scheduling metric shared types and constants
// Fixed-point constants, reciprocal table and the pipeline stage record.
// ----------------------------------------------------------------------------
package ersm_pkg;

  localparam logic [21:0] WEIGHT_SCALE = 22'd2880000;
  localparam logic [20:0] NUM_SCALE    = 21'd1536000;
  localparam logic [20:0] DEN_BASE     = 21'd256000;
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [20:0] X_LIMIT_Q16  = 21'd1441792;
  localparam logic [47:0] MAX48        = 48'hFFFF_FFFF_FFFF;

  // ceil(2^35 / k), exact floor division for dividends below 2^31
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [35:0] EXP_RECIP [1:12] = '{
    36'd34359738368, 36'd17179869184, 36'd11453246123, 36'd8589934592,
    36'd6871947674,  36'd5726623062,  36'd4908534053,  36'd4294967296,
    36'd3817748708,  36'd3435973837,  36'd3123612579,  36'd2863311531
  };

  // stage plan
  localparam int W_LAST     = 38;  // weight quotient, one bit per stage 1..38
  localparam int X_OVF      = 1;   // quotient overflow check
  localparam int X_FIRST    = 2;   // x quotient bits 20..0 in stages 2..22
  localparam int X_LAST     = 22;
  localparam int ST_CLAMP   = 23;
  localparam int N_FIRST    = 24;  // n bits 4..0 in stages 24..28
  localparam int N_LAST     = 28;
  localparam int E_FIRST    = 29;  // 12 taylor terms, two stages each
  localparam int E_LAST     = 52;
  localparam int ST_ROUND   = 53;
  localparam int ST_MUL     = 54;
  localparam int ST_OUT     = 55;
  localparam int NUM_STAGES = 56;

  typedef struct packed {
    logic        rt;
    logic        rate_zero;
    logic [31:0] rate;
    logic [37:0] wrem;
    logic [37:0] wq;
    logic [60:0] xrem;
    logic [44:0] den;
    logic [20:0] xq;
    logic        xovf;
    logic        sat;
    logic [34:0] xr;
    logic [4:0]  n;
    logic [30:0] term;
    logic [60:0] prod;
    logic [31:0] sum;
    logic [17:0] e16;
    logic [55:0] p;
    logic [47:0] metric;
  } stage_t;

endpackage

### src/exp_rule_scheduling_metric.sv
// ----------------------------------------------------------------------------
// exp_rule_scheduling_metric - EXP-rule priority metric pipeline
// Proportional-fair weight times exp of normalized HOL delay if real-time.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the output stalls or the square root below
// is busy. The depth is set by the bit-per-stage quotient of the delay ratio
// followed by the range reduction and the 12-term exponential series (a
// multiply stage and a reciprocal-divide stage per term). The weight quotient
// runs alongside. Writing avg_hol_delay_us starts a bit-serial square root;
// while it runs the input is not ready.
module exp_rule_scheduling_metric
  import ersm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        is_real_time_i,
  input  logic [15:0] spectral_eff_i,
  input  logic [31:0] avg_rate_bps_i,
  input  logic [23:0] hol_delay_us_i,
  input  logic [23:0] target_delay_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] metric_o,
  output logic        saturated_o
);

  // square root of the average delay, scaled to Q8
  logic [23:0] avg_q;
  logic [19:0] root_q, root_d;
  logic [4:0]  bit_q;
  logic        busy_q;
  logic [20:0] c_q;
  logic [19:0] trial;
  logic [39:0] trial_sq;

  assign trial    = root_q | (20'd1 << bit_q);
  assign trial_sq = 40'(trial) * 40'(trial);
  assign root_d   = (trial_sq <= {avg_q, 16'h0}) ? trial : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= '0;
      root_q <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
      c_q    <= DEN_BASE;
    end else if (cfg_we_i) begin
      avg_q  <= cfg_wdata_i;
      root_q <= '0;
      bit_q  <= 5'd19;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      root_q <= root_d;
      if (bit_q == 5'd0) begin
        busy_q <= 1'b0;
        c_q    <= DEN_BASE + 21'(root_d);
      end else begin
        bit_q <= bit_q - 5'd1;
      end
    end
  end

  // pipeline with a common advance
  logic [NUM_STAGES-1:0] v_q;
  stage_t                st_q [NUM_STAGES];
  stage_t                st_d [NUM_STAGES];
  logic                  en;

  assign en         = !v_q[ST_OUT] || out_ready_i;
  assign in_ready_o = en && !busy_q;

  always_comb begin
    st_d[0]           = '0;
    st_d[0].rt        = is_real_time_i;
    st_d[0].rate      = avg_rate_bps_i;
    st_d[0].rate_zero = (avg_rate_bps_i == 32'd0);
    st_d[0].wrem      = 38'(spectral_eff_i) * 38'(WEIGHT_SCALE);
    st_d[0].xrem      = {45'(hol_delay_us_i) * 45'(NUM_SCALE), 16'h0};
    st_d[0].den       = 45'(target_delay_us_i) * 45'(c_q);
    st_d[0].term      = ONE_Q30;
  end

  for (genvar i = 1; i < NUM_STAGES; i++) begin : g_stage
    localparam int WB = (i <= W_LAST) ? W_LAST - i : 0;
    localparam int XB = (i >= X_FIRST && i <= X_LAST) ? X_LAST - i : 0;
    localparam int NB = (i >= N_FIRST && i <= N_LAST) ? N_LAST - i : 0;
    localparam int KI = (i >= E_FIRST && i <= E_LAST) ? (i - E_FIRST) / 2 + 1 : 1;
    localparam bit EA = ((i - E_FIRST) % 2) == 0;

    logic [66:0] mq;
    logic [86:0] wide;

    always_comb begin
      st_d[i] = st_q[i-1];
      mq      = '0;
      wide    = '0;
      if (i <= W_LAST) begin
        if ((st_q[i-1].wrem >> WB) >= 38'(st_q[i-1].rate)) begin
          st_d[i].wrem   = st_q[i-1].wrem - (38'(st_q[i-1].rate) << WB);
          st_d[i].wq[WB] = 1'b1;
        end
      end
      if (i == X_OVF) begin
        if ((st_q[i-1].xrem >> 21) >= 61'(st_q[i-1].den)) begin
          st_d[i].xovf = 1'b1;
        end
      end
      if (i >= X_FIRST && i <= X_LAST) begin
        if ((st_q[i-1].xrem >> XB) >= 61'(st_q[i-1].den)) begin
          st_d[i].xrem   = st_q[i-1].xrem - (61'(st_q[i-1].den) << XB);
          st_d[i].xq[XB] = 1'b1;
        end
      end
      if (i == ST_CLAMP) begin
        if (st_q[i-1].xovf || st_q[i-1].xq > X_LIMIT_Q16) begin
          st_d[i].xr  = {X_LIMIT_Q16, 14'h0};
          st_d[i].sat = 1'b1;
        end else begin
          st_d[i].xr = {st_q[i-1].xq, 14'h0};
        end
      end
      // range reduction by ln2
      if (i >= N_FIRST && i <= N_LAST) begin
        if ((st_q[i-1].xr >> NB) >= 35'(LN2_Q30)) begin
          st_d[i].xr    = st_q[i-1].xr - (35'(LN2_Q30) << NB);
          st_d[i].n[NB] = 1'b1;
        end
      end
      if (i >= E_FIRST && i <= E_LAST) begin
        if (EA) begin
          st_d[i].sum  = st_q[i-1].sum + 32'(st_q[i-1].term);
          st_d[i].prod = 61'(st_q[i-1].term) * 61'(st_q[i-1].xr[29:0]);
        end else begin
          mq           = 67'(st_q[i-1].prod[60:30]) * 67'(EXP_RECIP[KI]);
          st_d[i].term = 31'(mq >> RECIP_SHIFT);
        end
      end
      if (i == ST_ROUND) begin
        st_d[i].e16 = 18'((33'(st_q[i-1].sum) + 33'(st_q[i-1].term) + 33'h2000) >> 14);
      end
      if (i == ST_MUL) begin
        st_d[i].p = 56'(st_q[i-1].wq) * 56'(st_q[i-1].e16);
      end
      if (i == ST_OUT) begin
        wide = 87'(st_q[i-1].p) << st_q[i-1].n;
        if (st_q[i-1].rate_zero) begin
          st_d[i].metric = MAX48;
          st_d[i].sat    = 1'b1;
        end else if (!st_q[i-1].rt) begin
          st_d[i].metric = 48'(st_q[i-1].wq);
          st_d[i].sat    = 1'b0;
        end else if (|wide[86:64]) begin
          st_d[i].metric = MAX48;
          st_d[i].sat    = 1'b1;
        end else begin
          st_d[i].metric = wide[63:16];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NUM_STAGES-2:0], in_valid_i && in_ready_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o = v_q[ST_OUT];
  assign metric_o    = st_q[ST_OUT].metric;
  assign saturated_o = st_q[ST_OUT].sat;

endmodule
